/* hdl/acl_pkg.sv */
// shared constants, types and codes for the adc calibration table builder
// no dependencies; used by acl_interp and adc_calibration_lut_builder
`default_nettype none

package acl_pkg;

	// table geometry
	localparam int NUM_CODES        = 257;
	localparam int SAMPLES_PER_CODE = 16;
	localparam int SAMPLE_BITS      = 12;

	// field and storage widths
	localparam int ADDR_W  = $clog2(NUM_CODES);
	localparam int COL_W   = $clog2(SAMPLES_PER_CODE);
	localparam int SUM_W   = 16;
	localparam int ENTRY_W = 13;
	localparam int CODE_W  = 9;
	localparam int PASS_W  = 4;
	localparam int VALUE_W = 20;
	localparam int FRAC_W  = 8;

	// full-scale code, saturated sum and forced output
	localparam logic [SAMPLE_BITS-1:0] FULL_CODE  = {SAMPLE_BITS{1'b1}};
	localparam logic [SUM_W-1:0]       FULL_SUM   = SUM_W'(SAMPLES_PER_CODE * ((1 << SAMPLE_BITS) - 1));
	localparam logic [VALUE_W-1:0]     FULL_VALUE = VALUE_W'(((1 << SAMPLE_BITS) - 1) << FRAC_W);
	localparam logic [ADDR_W-1:0]      LAST_ANCHOR = ADDR_W'(NUM_CODES - 1);

	// command carried on tuser
	typedef enum logic [0:0] {
		CMD_ACCUM = 1'b0,
		CMD_READ  = 1'b1
	} cmd_t;

	// interpolation result
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               full_scale;
	} interp_out_t;

endpackage

`default_nettype wire

/* hdl/acl_ram.sv */
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`default_nettype none

module acl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 257
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/acl_interp.sv */
// interpolation between two anchor sums with full-scale and end handling
// depends on acl_pkg
`default_nettype none

module acl_interp (
	input  wire logic [acl_pkg::SUM_W-1:0]  sum_a,
	input  wire logic [acl_pkg::SUM_W-1:0]  sum_b,
	input  wire logic [acl_pkg::COL_W-1:0]  col,
	input  wire logic                       last_anchor,
	input  wire logic                       in_range,
	output      acl_pkg::interp_out_t       result
);

	localparam int NUM_W = acl_pkg::SUM_W + acl_pkg::COL_W + 1;

	logic [acl_pkg::SUM_W-1:0] next_sum;
	logic [acl_pkg::COL_W:0]   weight_a;
	logic [NUM_W-1:0]          num;

	// weights: the sum of two averages times 16 columns already equals q12.8 at 16 samples
	// column 0 and the last anchor never look at the next anchor's sum
	always_comb begin
		next_sum = (last_anchor || col == '0) ? sum_a : sum_b;
		weight_a = (acl_pkg::COL_W+1)'(acl_pkg::SAMPLES_PER_CODE) - {1'b0, col};
		num      = NUM_W'(sum_a) * NUM_W'(weight_a) + NUM_W'(next_sum) * NUM_W'(col);
	end

	// select between out of range, forced full scale and interpolated value
	always_comb begin
		if (!in_range) begin
			result.value      = '0;
			result.full_scale = 1'b0;
		end else if (col != '0 && sum_a == acl_pkg::FULL_SUM) begin
			result.value      = acl_pkg::FULL_VALUE;
			result.full_scale = 1'b1;
		end else begin
			result.value      = num[acl_pkg::VALUE_W-1:0];
			result.full_scale = 1'b0;
		end
	end

endmodule

`default_nettype wire

/* hdl/adc_calibration_lut_builder.sv */
// top level: stream ports, sum memories, accumulate update and output register
// depends on acl_pkg, acl_ram and acl_interp
`default_nettype none

// Takes one word per clock. An accumulate word (tuser 0) reads the code's running sum
// from memory, adds or restarts it with the sample, saturates at 16 x 4095 and writes it
// back from stage 1; it gives no output. A read word (tuser 1) reads this anchor and the
// next one from two copies of the sum memory and delivers the q12.8 value through an
// output register after stage 1, so the input keeps flowing while a result waits.
// A write forwarded into the following word keeps back-to-back accumulates on the same code
// exact. The input stalls only while a read word waits behind an output word that is not
// taken. Sums of codes never accumulated read as undefined; there is no clearing pass
// after reset.
module adc_calibration_lut_builder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	// code[8:0], pass_index[12:9], sample[24:13], entry[37:25], zero pad[39:38]
	input  wire logic [39:0] s_tdata,
	// cmd[0]
	input  wire logic [0:0]  s_tuser,
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	// value[19:0], zero pad[23:20]
	output      logic [23:0] m_tdata,
	// full_scale[0]
	output      logic [0:0]  m_tuser
);

	localparam int ADDR_W = acl_pkg::ADDR_W;
	localparam int SUM_W  = acl_pkg::SUM_W;
	localparam int COL_W  = acl_pkg::COL_W;

	// input field split
	acl_pkg::cmd_t                     in_cmd;
	logic [acl_pkg::CODE_W-1:0]        in_code;
	logic [acl_pkg::PASS_W-1:0]        in_pass;
	logic [acl_pkg::SAMPLE_BITS-1:0]   in_sample;
	logic [acl_pkg::ENTRY_W-1:0]       in_entry;
	logic [acl_pkg::ENTRY_W-COL_W-1:0] in_anchor;
	logic                              accept;

	// stage 1 registers
	logic                              s1_valid_q;
	acl_pkg::cmd_t                     cmd_s1;
	logic                              in_range_s1;
	logic                              pass_zero_s1;
	logic [acl_pkg::SAMPLE_BITS-1:0]   sample_s1;
	logic [ADDR_W-1:0]                 addr_a_s1;
	logic [ADDR_W:0]                   addr_b_s1;
	logic [COL_W-1:0]                  col_s1;
	logic                              last_s1;
	logic                              s1_drain;

	// memory and forwarding
	logic [ADDR_W-1:0]                 rd_addr_a;
	logic [ADDR_W:0]                   rd_addr_b;
	logic [SUM_W-1:0]                  rdata_a;
	logic [SUM_W-1:0]                  rdata_b;
	logic                              ram_we;
	logic [SUM_W-1:0]                  wr_sum;
	logic                              fwd_valid_q;
	logic [ADDR_W-1:0]                 fwd_addr_q;
	logic [SUM_W-1:0]                  fwd_data_q;
	logic [SUM_W-1:0]                  sum_a;
	logic [SUM_W-1:0]                  sum_b;
	logic [SUM_W:0]                    sum_add;

	// output register
	logic                              out_valid_q;
	logic [acl_pkg::VALUE_W-1:0]       out_value_q;
	logic                              out_fs_q;
	acl_pkg::interp_out_t              interp;

	// unpack the input word
	always_comb begin
		in_cmd    = acl_pkg::cmd_t'(s_tuser[0]);
		in_code   = s_tdata[8:0];
		in_pass   = s_tdata[12:9];
		in_sample = s_tdata[24:13];
		in_entry  = s_tdata[37:25];
		in_anchor = in_entry[acl_pkg::ENTRY_W-1:COL_W];
	end

	// handshake: stage 1 moves on unless a read waits for a held output
	assign s1_drain = (cmd_s1 == acl_pkg::CMD_ACCUM) || !out_valid_q || m_tready;
	assign s_tready = !s1_valid_q || s1_drain;
	assign accept   = s_tvalid && s_tready;

	// read addresses: code or anchor on copy a, next anchor on copy b
	always_comb begin
		if (in_cmd == acl_pkg::CMD_ACCUM) begin
			rd_addr_a = in_code[ADDR_W-1:0];
		end else begin
			rd_addr_a = in_anchor[ADDR_W-1:0];
		end
		rd_addr_b = {1'b0, in_anchor[ADDR_W-1:0]} + (ADDR_W+1)'(1);
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_drain) begin
			s1_valid_q <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1       <= in_cmd;
			pass_zero_s1 <= (in_pass == '0);
			sample_s1    <= in_sample;
			addr_a_s1    <= rd_addr_a;
			addr_b_s1    <= rd_addr_b;
			col_s1       <= in_entry[COL_W-1:0];
			last_s1      <= (in_anchor == (acl_pkg::ENTRY_W-COL_W)'(acl_pkg::LAST_ANCHOR));
			if (in_cmd == acl_pkg::CMD_ACCUM) begin
				in_range_s1 <= (in_code < acl_pkg::CODE_W'(acl_pkg::NUM_CODES));
			end else begin
				in_range_s1 <= (in_anchor < (acl_pkg::ENTRY_W-COL_W)'(acl_pkg::NUM_CODES));
			end
		end
	end

	// sum memory, two copies written together
	acl_ram #(.WIDTH(SUM_W), .DEPTH(acl_pkg::NUM_CODES)) u_ram_a (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_a_s1),
		.wdata (wr_sum),
		.re    (accept),
		.raddr (rd_addr_a),
		.rdata (rdata_a)
	);

	acl_ram #(.WIDTH(SUM_W), .DEPTH(acl_pkg::NUM_CODES)) u_ram_b (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_a_s1),
		.wdata (wr_sum),
		.re    (accept),
		.raddr (rd_addr_b[ADDR_W-1:0]),
		.rdata (rdata_b)
	);

	// forward the write made at the same edge as this word's read
	always_comb begin
		sum_a = rdata_a;
		sum_b = rdata_b;
		if (fwd_valid_q && fwd_addr_q == addr_a_s1) begin
			sum_a = fwd_data_q;
		end
		if (fwd_valid_q && {1'b0, fwd_addr_q} == addr_b_s1) begin
			sum_b = fwd_data_q;
		end
	end

	// accumulate: restart or add, saturating at the full-scale sum
	always_comb begin
		sum_add = {1'b0, sum_a} + (SUM_W+1)'(sample_s1);
		if (pass_zero_s1) begin
			wr_sum = SUM_W'(sample_s1);
		end else if (sum_add > (SUM_W+1)'(acl_pkg::FULL_SUM)) begin
			wr_sum = acl_pkg::FULL_SUM;
		end else begin
			wr_sum = sum_add[SUM_W-1:0];
		end
		ram_we = s1_valid_q && cmd_s1 == acl_pkg::CMD_ACCUM && in_range_s1;
	end

	// forwarding register follows stage 1 as it moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (s1_drain) begin
			fwd_valid_q <= ram_we;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			fwd_addr_q <= addr_a_s1;
			fwd_data_q <= wr_sum;
		end
	end

	// interpolation of a read word
	acl_interp u_interp (
		.sum_a       (sum_a),
		.sum_b       (sum_b),
		.col         (col_s1),
		.last_anchor (last_s1),
		.in_range    (in_range_s1),
		.result      (interp)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_valid_q && cmd_s1 == acl_pkg::CMD_READ && s1_drain) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && cmd_s1 == acl_pkg::CMD_READ && s1_drain) begin
			out_value_q <= interp.value;
			out_fs_q    <= interp.full_scale;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = {4'b0, out_value_q};
	assign m_tuser[0] = out_fs_q;

	// stage 1 only waits when a read sits behind a held output word
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_drain) |-> (cmd_s1 == acl_pkg::CMD_READ && m_tvalid && !m_tready))
		else $error("stage 1 stalled without output back-pressure");

	// memory writes stay inside the table
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (addr_a_s1 <= acl_pkg::LAST_ANCHOR))
		else $error("sum write outside the table");

	// forwarding only becomes valid after an accumulate in stage 1
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fwd_valid_q) |-> $past(s1_valid_q && cmd_s1 == acl_pkg::CMD_ACCUM))
		else $error("forward register set without an accumulate");

	// a forced word always carries the full-scale value
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[19:0] == acl_pkg::FULL_VALUE))
		else $error("full-scale flag with a wrong value");

endmodule

`default_nettype wire
